// ===== hw/rtl/touch_average_and_calibrate_core_defines.svh =====
// Assertion macros shared by the touch averaging block.
`ifndef TOUCH_AVERAGE_AND_CALIBRATE_CORE_DEFINES_SVH
`define TOUCH_AVERAGE_AND_CALIBRATE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tac_pkg.sv =====
package tac_pkg;

    localparam int CONV_W = 12;
    localparam int SUM_W  = 16;
    localparam int POS_W  = 16;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;
    localparam int FRAC_W = 16;

    localparam logic [CONV_W-1:0] FULL_SCALE = 12'd4095;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ORIENTATION = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCALE_X     = 3'd1;
    localparam logic [IDX_W-1:0] REG_SCALE_Y     = 3'd2;
    localparam logic [IDX_W-1:0] REG_BIAS_X      = 3'd3;
    localparam logic [IDX_W-1:0] REG_BIAS_Y      = 3'd4;

    // orientation codes
    localparam logic [2:0] ORIENT_INV_X     = 3'd1;
    localparam logic [2:0] ORIENT_SWAP_INV  = 3'd2;
    localparam logic [2:0] ORIENT_INV_Y     = 3'd3;
    localparam logic [2:0] ORIENT_SWAP      = 3'd4;

    localparam logic signed [CFG_W-1:0] SCALE_ONE = 32'sd65536;

    typedef struct packed {
        logic take;    // item accepted this cycle
        logic last;    // item at the last run position; closes the run if taken
        logic adv;     // pipeline moves this cycle
    } lane_ctl_t;

    typedef struct packed {
        logic [CONV_W-1:0]       mean;
        logic signed [POS_W-1:0] pos;
    } lane_res_t;

endpackage

// ===== hw/rtl/touch_average_and_calibrate_core.sv =====
// Touch averaging and calibration core. Each item is one pair of 12-bit
// conversions; it is mapped to screen axes by the orientation register and
// added into per-axis sums. Every SAMPLES_PER_POINT items the block emits one
// result: per axis the mean floor(sum/N) and the Q15.16 position
// scale*mean+bias, truncated toward zero and saturated to 16 bits. One item
// is taken every cycle; the closing sum is registered, divided, multiplied,
// then biased and saturated into the output register, and input stalls only
// while a finished result waits in the output register.
// Registers are written through the cfg port, always ready; the user writes
// them only while the core is idle, which the block itself does not enforce;
// index 0 orientation, 1/2 scale x/y, 3/4 bias x/y.
module touch_average_and_calibrate_core
    import tac_pkg::*;
#(
    parameter int SAMPLES_PER_POINT = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CONV_W-1:0]       conv_x,
    input  logic [CONV_W-1:0]       conv_y,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CONV_W-1:0]       mean_x,
    output logic [CONV_W-1:0]       mean_y,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

`include "touch_average_and_calibrate_core_defines.svh"

    localparam int CNT_W = $clog2(SAMPLES_PER_POINT + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_POINT - 1);

    logic [2:0]              orientation_reg;
    logic signed [CFG_W-1:0] scale_x_reg, scale_y_reg, bias_x_reg, bias_y_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    v1_reg, v2_reg, v3_reg;
    logic                    advance, accept, last;
    logic [CONV_W-1:0]       map_x, map_y;
    lane_ctl_t               ctl;
    lane_res_t               res_x, res_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg <= ORIENT_INV_X;
            scale_x_reg     <= SCALE_ONE;
            scale_y_reg     <= SCALE_ONE;
            bias_x_reg      <= '0;
            bias_y_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ORIENTATION: orientation_reg <= cfg_data[2:0];
                REG_SCALE_X:     scale_x_reg     <= $signed(cfg_data);
                REG_SCALE_Y:     scale_y_reg     <= $signed(cfg_data);
                REG_BIAS_X:      bias_x_reg      <= $signed(cfg_data);
                REG_BIAS_Y:      bias_y_reg      <= $signed(cfg_data);
                default:         ;
            endcase
        end
    end

    // axis mapping; undefined codes pass the pair through
    always_comb
    begin
        case (orientation_reg)
            ORIENT_INV_X:
            begin
                map_x = FULL_SCALE - conv_x;
                map_y = conv_y;
            end
            ORIENT_SWAP_INV:
            begin
                map_x = FULL_SCALE - conv_y;
                map_y = FULL_SCALE - conv_x;
            end
            ORIENT_INV_Y:
            begin
                map_x = conv_x;
                map_y = FULL_SCALE - conv_y;
            end
            ORIENT_SWAP:
            begin
                map_x = conv_y;
                map_y = conv_x;
            end
            default:
            begin
                map_x = conv_x;
                map_y = conv_y;
            end
        endcase
    end

    assign in_ready = advance;
    assign accept   = in_valid && in_ready;
    assign last     = (count_reg == LAST_CNT);

    assign ctl.take = accept;
    assign ctl.last = last;
    assign ctl.adv  = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= last ? '0 : count_reg + 1'b1;
            end
            if (advance)
            begin
                v1_reg <= accept && last;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    tac_lane #(
        .SAMPLES_PER_POINT(SAMPLES_PER_POINT)
    ) u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .sample (map_x),
        .scale  (scale_x_reg),
        .bias   (bias_x_reg),
        .res    (res_x)
    );

    tac_lane #(
        .SAMPLES_PER_POINT(SAMPLES_PER_POINT)
    ) u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .sample (map_y),
        .scale  (scale_y_reg),
        .bias   (bias_y_reg),
        .res    (res_y)
    );

    tac_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (v3_reg),
        .res_x     (res_x),
        .res_y     (res_y),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .mean_x    (mean_x),
        .mean_y    (mean_y),
        .pos_x     (pos_x),
        .pos_y     (pos_y)
    );

    `TAC_ASSERT_NOW(a_count_range, 1'b1, count_reg <= LAST_CNT, "sample count past run length")
    `TAC_ASSERT_NEXT(a_run_close, accept && last, v1_reg && count_reg == '0,
        "closing item did not start a result")
    `TAC_ASSERT_NEXT(a_count_step, accept && !last, count_reg == $past(count_reg) + 1'b1,
        "sample count did not advance")
    `TAC_ASSERT_NOW(a_out_source, $rose(out_valid), $past(v3_reg), "result without pipeline item")

endmodule

// ===== hw/rtl/tac_lane.sv =====
module tac_lane
    import tac_pkg::*;
#(
    parameter int SAMPLES_PER_POINT = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_ctl_t               ctl,
    input  logic [CONV_W-1:0]       sample,
    input  logic signed [CFG_W-1:0] scale,
    input  logic signed [CFG_W-1:0] bias,
    output lane_res_t               res
);

    // floor(sum / N) as (sum * ceil(2^21 / N)) >> 21, exact for 16-bit sums, N <= 16
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2**RECIP_SHIFT + SAMPLES_PER_POINT - 1) / SAMPLES_PER_POINT);
    localparam int DIV_W  = SUM_W + RECIP_W;
    localparam int PROD_W = CFG_W + CONV_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int Q_W    = ACC_W - FRAC_W;

    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [SUM_W-1:0]         s1_sum_reg;
    logic [CONV_W-1:0]        s2_mean_reg;
    logic [CONV_W-1:0]        s3_mean_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic [DIV_W-1:0]         div_prod;
    logic signed [ACC_W-1:0]  acc;
    logic signed [Q_W-1:0]    q;
    logic signed [POS_W-1:0]  pos;

    assign sum_next = sum_reg + SUM_W'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctl.take)
        begin
            sum_reg <= ctl.last ? '0 : sum_next;
        end
    end

    assign div_prod = s1_sum_reg * RECIP;

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            s1_sum_reg  <= sum_next;
            s2_mean_reg <= div_prod[RECIP_SHIFT +: CONV_W];
            s3_mean_reg <= s2_mean_reg;
            s3_prod_reg <= scale * $signed({1'b0, s2_mean_reg});
        end
    end

    // truncate toward zero: arithmetic shift, plus one for negatives with a fraction
    always_comb
    begin
        acc = ACC_W'(s3_prod_reg) + ACC_W'(bias);
        q   = acc[ACC_W-1:FRAC_W] + Q_W'(acc[ACC_W-1] && (|acc[FRAC_W-1:0]));
        if (q > Q_W'(32767))
        begin
            pos = 16'sh7FFF;
        end
        else if (q < -Q_W'(32768))
        begin
            pos = 16'sh8000;
        end
        else
        begin
            pos = q[POS_W-1:0];
        end
    end

    assign res.mean = s3_mean_reg;
    assign res.pos  = pos;

endmodule

// ===== hw/rtl/tac_merge.sv =====
module tac_merge
    import tac_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    res_valid,
    input  lane_res_t               res_x,
    input  lane_res_t               res_y,
    output logic                    advance,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CONV_W-1:0]       mean_x,
    output logic [CONV_W-1:0]       mean_y,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y
);

    logic      valid_reg;
    lane_res_t x_reg;
    lane_res_t y_reg;

    // output register frees up when empty or being taken
    assign advance = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= res_x;
            y_reg <= res_y;
        end
    end

    assign out_valid = valid_reg;
    assign mean_x    = x_reg.mean;
    assign mean_y    = y_reg.mean;
    assign pos_x     = x_reg.pos;
    assign pos_y     = y_reg.pos;

endmodule
